// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms on clk with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/dogkp_pkg.sv
// ----------------------------------------------------------------------------
// dogkp_pkg
// Types and constants of the DoG extremum keypoint detector.
// ----------------------------------------------------------------------------
package dogkp_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 15;
  localparam int POS_W     = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO  = 2'd3;

  localparam logic [1:0] EXT_NONE = 2'd0;
  localparam logic [1:0] EXT_MAX  = 2'd1;
  localparam logic [1:0] EXT_MIN  = 2'd2;

  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [10:0] HEIGHT_RST = 11'd480;
  localparam logic [14:0] THRESH_RST = 15'd492;
  localparam logic [5:0]  RATIO_RST  = 6'd10;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] b;
    logic signed [SAMPLE_W-1:0] m;
    logic signed [SAMPLE_W-1:0] a;
  } trip_t;

  typedef struct packed {
    logic             center_valid;
    logic             is_keypoint;
    logic [1:0]       extremum_kind;
    logic [POS_W-1:0] center_row;
    logic [POS_W-1:0] center_col;
  } result_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic read;
    logic shift;
    logic cmp;
    logic mul1;
    logic mul2;
    logic mul3;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_free;
  } dp_stat_t;

endpackage

// File: hw/rtl/dogkp_if.sv
// ----------------------------------------------------------------------------
// dogkp channel interfaces
// Valid/ready channels for sample triples and detection results.
// ----------------------------------------------------------------------------
interface dog_in_if;
  import dogkp_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] dog_below;
  logic signed [SAMPLE_W-1:0] dog_mid;
  logic signed [SAMPLE_W-1:0] dog_above;
  logic                       frame_start;
  modport source (output valid, dog_below, dog_mid, dog_above, frame_start, input ready);
  modport sink (input valid, dog_below, dog_mid, dog_above, frame_start, output ready);
endinterface

interface dog_out_if;
  import dogkp_pkg::*;
  logic             valid;
  logic             ready;
  logic             center_valid;
  logic             is_keypoint;
  logic [1:0]       extremum_kind;
  logic [POS_W-1:0] center_row;
  logic [POS_W-1:0] center_col;
  modport source (output valid, center_valid, is_keypoint, extremum_kind, center_row,
                  center_col, input ready);
  modport sink (input valid, center_valid, is_keypoint, extremum_kind, center_row,
                center_col, output ready);
endinterface

// File: hw/rtl/dogkp_ctrl.sv
// ----------------------------------------------------------------------------
// dogkp_ctrl
// Sequencer: line store clear, then per-transaction read, shift, test steps.
// ----------------------------------------------------------------------------
module dogkp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dogkp_pkg::dp_stat_t stat,
  output dogkp_pkg::dp_cmd_t  cmd
);
  import dogkp_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_SHIFT, S_CMP, S_MUL1, S_MUL2, S_MUL3, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) state_nxt = S_RD;
      end
      S_RD: begin
        cmd.read  = 1'b1;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

// File: hw/rtl/dogkp_dpath.sv
// ----------------------------------------------------------------------------
// dogkp_dpath
// Counters, line stores, 3x3 window, extremum and Hessian edge test datapath.
// ----------------------------------------------------------------------------
module dogkp_dpath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dogkp_pkg::dp_cmd_t                 cmd,
  output dogkp_pkg::dp_stat_t                stat,
  input  logic                               cfg_we,
  input  logic [dogkp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dogkp_pkg::CFG_DAT_W-1:0]    cfg_wdata,
  input  logic signed [dogkp_pkg::SAMPLE_W-1:0] in_below,
  input  logic signed [dogkp_pkg::SAMPLE_W-1:0] in_mid,
  input  logic signed [dogkp_pkg::SAMPLE_W-1:0] in_above,
  input  logic                               in_frame_start,
  output logic                               out_valid,
  input  logic                               out_ready,
  output dogkp_pkg::result_t                 out_res
);
  import dogkp_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WX = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int RX = (RW + 1 > 11) ? RW + 1 : 11;

  logic [10:0] width_r, height_r;
  logic [14:0] thresh_r;
  logic [5:0]  ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      thresh_r <= THRESH_RST;
      ratio_r  <= RATIO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_wdata[10:0];
        CFG_HEIGHT: height_r <= cfg_wdata[10:0];
        CFG_THRESH: thresh_r <= cfg_wdata;
        CFG_RATIO:  ratio_r  <= cfg_wdata[5:0];
        default:    ;
      endcase
    end
  end

  // effective frame size
  logic [WX-1:0] w_eff;
  logic [RX-1:0] h_eff;

  always_comb begin
    if (WX'(width_r) < WX'(3)) w_eff = WX'(3);
    else if (WX'(width_r) > WX'(MAX_WIDTH)) w_eff = WX'(MAX_WIDTH);
    else w_eff = WX'(width_r);
    if (RX'(height_r) < RX'(3)) h_eff = RX'(3);
    else if (RX'(height_r) > RX'(MAX_HEIGHT)) h_eff = RX'(MAX_HEIGHT);
    else h_eff = RX'(height_r);
  end

  // position counters
  logic [RW-1:0] row_r, r_r;
  logic [CW-1:0] col_r, c_r;
  logic [RX-1:0] rc, rn;
  logic [WX-1:0] cc, cn;

  always_comb begin
    rc = in_frame_start ? '0 : RX'(row_r);
    cc = in_frame_start ? '0 : WX'(col_r);
    if (cc >= w_eff) begin
      cc = '0;
      rc = rc + RX'(1);
    end
    if (rc >= h_eff) rc = '0;
    cn = cc + WX'(1);
    rn = rc;
    if (cn >= w_eff) begin
      cn = '0;
      rn = rc + RX'(1);
      if (rn >= h_eff) rn = '0;
    end
  end

  trip_t cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.accept) begin
      row_r <= RW'(rn);
      col_r <= CW'(cn);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      r_r   <= RW'(rc);
      c_r   <= CW'(cc);
      cur_r <= '{b: in_below, m: in_mid, a: in_above};
    end
  end

  // line stores
  trip_t         prev_mem  [MAX_WIDTH];
  trip_t         prev2_mem [MAX_WIDTH];
  trip_t         rd_prev_r, rd_prev2_r;
  logic [CW-1:0] clr_r;
  logic [CW-1:0] wr_addr;
  trip_t         wr_prev, wr_prev2;
  logic          wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear) begin
      clr_r <= clr_r + CW'(1);
    end
  end

  assign stat.clear_done = (clr_r == CW'(MAX_WIDTH - 1));

  assign wr_en    = cmd.clear | cmd.shift;
  assign wr_addr  = cmd.clear ? clr_r : c_r;
  assign wr_prev  = cmd.clear ? '0 : cur_r;
  assign wr_prev2 = cmd.clear ? '0 : rd_prev_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prev_mem[wr_addr]  <= wr_prev;
      prev2_mem[wr_addr] <= wr_prev2;
    end
    if (cmd.read) begin
      rd_prev_r  <= prev_mem[c_r];
      rd_prev2_r <= prev2_mem[c_r];
    end
  end

  // window: index is column * 3 + row
  trip_t win_r [9];

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int k = 0; k < 6; k++) win_r[k] <= win_r[k+3];
      win_r[6] <= rd_prev2_r;
      win_r[7] <= rd_prev_r;
      win_r[8] <= cur_r;
    end
  end

  // extremum and contrast
  logic signed [SAMPLE_W-1:0] v;
  logic                       gt, lt;
  logic [SAMPLE_W:0]          mag;
  logic [1:0]                 kind_nxt;

  assign v   = win_r[4].m;
  assign mag = v[SAMPLE_W-1] ? (SAMPLE_W+1)'(-(SAMPLE_W+1)'(v)) : (SAMPLE_W+1)'(v);

  always_comb begin
    gt = 1'b1;
    lt = 1'b1;
    for (int k = 0; k < 9; k++) begin
      if (!(v > win_r[k].b && v > win_r[k].a)) gt = 1'b0;
      if (!(v < win_r[k].b && v < win_r[k].a)) lt = 1'b0;
      if (k != 4) begin
        if (!(v > win_r[k].m)) gt = 1'b0;
        if (!(v < win_r[k].m)) lt = 1'b0;
      end
    end
    kind_nxt = EXT_NONE;
    if (mag >= (SAMPLE_W+1)'(thresh_r)) begin
      if (gt) kind_nxt = EXT_MAX;
      else if (lt) kind_nxt = EXT_MIN;
    end
  end

  // Hessian terms, scaled by 4
  logic signed [19:0] dxx_r, dyy_r;
  logic signed [17:0] dxy_r;
  logic signed [20:0] t_r;
  logic signed [19:0] dxx_nxt, dyy_nxt;
  logic signed [17:0] dxy_nxt;
  logic [1:0]         kind_r;

  assign dxx_nxt = (20'(win_r[3].m) + 20'(win_r[5].m) - (20'(v) <<< 1)) <<< 2;
  assign dyy_nxt = (20'(win_r[1].m) + 20'(win_r[7].m) - (20'(v) <<< 1)) <<< 2;
  assign dxy_nxt = 18'(win_r[0].m) + 18'(win_r[8].m) - 18'(win_r[2].m) - 18'(win_r[6].m);

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      kind_r <= kind_nxt;
      dxx_r  <= dxx_nxt;
      dyy_r  <= dyy_nxt;
      dxy_r  <= dxy_nxt;
      t_r    <= 21'(dxx_nxt) + 21'(dyy_nxt);
    end
  end

  logic signed [39:0] p_xxyy_r, p_xxyy_s;
  logic signed [35:0] p_xy_r, p_xy_s;
  logic signed [41:0] tt_s;
  logic [41:0]        tt_r;
  logic signed [40:0] det_r;
  logic [47:0]        lhs_r;
  logic [12:0]        kk_r;
  logic [6:0]         r1;
  logic [53:0]        rhs_r;
  logic               det_pos_r;

  assign p_xxyy_s = dxx_r * dyy_r;
  assign p_xy_s   = dxy_r * dxy_r;
  assign tt_s     = t_r * t_r;
  assign r1       = 7'(ratio_r) + 7'd1;

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      p_xxyy_r <= p_xxyy_s;
      p_xy_r   <= p_xy_s;
      tt_r     <= tt_s;
    end
    if (cmd.mul2) begin
      det_r <= 41'(p_xxyy_r) - 41'(p_xy_r);
      lhs_r <= 48'(tt_r) * 48'(ratio_r);
      kk_r  <= 13'(14'(r1) * 14'(r1));
    end
    if (cmd.mul3) begin
      det_pos_r <= (det_r > 41'sd0);
      rhs_r     <= 54'(det_r[39:0]) * 54'(kk_r);
    end
  end

  // result register
  logic    out_valid_r;
  result_t res_r, res_nxt;
  logic    border;

  assign border = (r_r < RW'(2)) || (c_r < CW'(2));

  always_comb begin
    res_nxt = '0;
    if (!border) begin
      res_nxt.center_valid  = 1'b1;
      res_nxt.extremum_kind = kind_r;
      res_nxt.is_keypoint   = (kind_r != EXT_NONE) && det_pos_r
                              && (54'(lhs_r) <= rhs_r);
      res_nxt.center_row    = POS_W'(r_r - RW'(1));
      res_nxt.center_col    = POS_W'(c_r - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) res_r <= res_nxt;
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_res       = res_r;

endmodule

// File: hw/rtl/dog_extremum_keypoint_detect_unit.sv
// ----------------------------------------------------------------------------
// dog_extremum_keypoint_detect_unit
// Operation: one input transaction in flight at a time; in ready stays low while
// the sequencer walks line store read, window shift, compare and three multiply
// steps, then waits for the result register to be free before loading it.
// Reset: synchronous; then a line store clear of all MAX_WIDTH entries with in ready low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dog_extremum_keypoint_detect_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  dog_in_if.sink                          in_ch,
  dog_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [dogkp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dogkp_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import dogkp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  result_t  res;
  logic     in_ready;
  logic     out_valid;

  dogkp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dogkp_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_below       (in_ch.dog_below),
    .in_mid         (in_ch.dog_mid),
    .in_above       (in_ch.dog_above),
    .in_frame_start (in_ch.frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ch.ready),
    .out_res        (res)
  );

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.center_valid  = res.center_valid;
  assign out_ch.is_keypoint   = res.is_keypoint;
  assign out_ch.extremum_kind = res.extremum_kind;
  assign out_ch.center_row    = res.center_row;
  assign out_ch.center_col    = res.center_col;

  `ASSERT_NEXT(a_one_in_flight, in_ch.valid && in_ready, !in_ready, "accepted while busy")
  `ASSERT_IMPL(a_border_quiet, out_valid && !res.center_valid,
               !res.is_keypoint && res.extremum_kind == EXT_NONE, "border result not zero")
  `ASSERT_IMPL(a_key_has_kind, out_valid && res.is_keypoint,
               res.extremum_kind != EXT_NONE, "keypoint without extremum")
  `ASSERT_IMPL(a_load_free, cmd.load_out, stat.out_free, "result overwritten")

endmodule

// File: verif/tb_dog_extremum_keypoint_detect_unit.sv
// ----------------------------------------------------------------------------
// tb_dog_extremum_keypoint_detect_unit
// Streams difference-of-Gaussian sample triples into the detector and checks
// every result transaction against a cycle-free scale-space extremum
// predictor (window build-up, border suppression, strict 26-neighbour max/min,
// contrast threshold, Hessian edge test) or, for the directed table of small
// frames, its entries. Random frames then run over several size, threshold and
// ratio settings, with random idle bursts on both channels bar the last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dog_extremum_keypoint_detect_unit;
  import dogkp_pkg::*;

  localparam int MAXW      = 1024;
  localparam int MAXH      = 1024;
  localparam int STALL_MAX = 20000;
  localparam int DRAIN_CYC = 24;

  typedef struct {
    logic signed [SAMPLE_W-1:0] b;
    logic signed [SAMPLE_W-1:0] m;
    logic signed [SAMPLE_W-1:0] a;
    bit                         fs;
    bit                         has_exp;
    result_t                    exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WIDTH;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  dog_in_if  in_ch();
  dog_out_if out_ch();

  dog_extremum_keypoint_detect_unit #(.MAX_WIDTH(MAXW), .MAX_HEIGHT(MAXH)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.dog_below   = '0;
    in_ch.dog_mid     = '0;
    in_ch.dog_above   = '0;
    in_ch.frame_start = 1'b0;
    out_ch.ready      = 1'b0;
  end

  // predictor state
  logic [10:0] cfg_width_q  = WIDTH_RST;
  logic [10:0] cfg_height_q = HEIGHT_RST;
  logic [14:0] cfg_thresh_q = THRESH_RST;
  logic [5:0]  cfg_ratio_q  = RATIO_RST;
  trip_t       prev_line [MAXW];
  trip_t       prev2_line[MAXW];
  trip_t       win[9];
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;

  result_t     pending_results[$];
  int          errors = 0;
  int          sent_cnt = 0;
  int          centre_cnt = 0;
  int          key_cnt = 0;
  int          max_cnt = 0;
  int          min_cnt = 0;
  bit          idle_on = 1'b1;
  int          recv_stall = 0;
  int          quiet_cycles = 0;
  stim_row_t   dir_table[27];

  initial begin
    foreach (prev_line[i]) begin
      prev_line[i]  = '0;
      prev2_line[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
  end

  function automatic result_t detect_extremum(trip_t cur, bit fs);
    int unsigned w, h, r, c;
    result_t     res;
    longint      v, dxx, dyy, dxy, t, det, kk, lhs, mag;
    bit          gt, lt;
    w = (cfg_width_q < 3) ? 3 : (cfg_width_q > MAXW) ? MAXW : cfg_width_q;
    h = (cfg_height_q < 3) ? 3 : (cfg_height_q > MAXH) ? MAXH : cfg_height_q;
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    for (int k = 0; k < 6; k++) win[k] = win[k+3];
    win[6] = prev2_line[c];
    win[7] = prev_line[c];
    win[8] = cur;
    prev2_line[c] = prev_line[c];
    prev_line[c]  = cur;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
    res = '0;
    if (r < 2 || c < 2) return res;
    v  = win[4].m;
    gt = 1'b1;
    lt = 1'b1;
    for (int k = 0; k < 9; k++) begin
      if (!(v > longint'(win[k].b) && v > longint'(win[k].a))) gt = 1'b0;
      if (!(v < longint'(win[k].b) && v < longint'(win[k].a))) lt = 1'b0;
      if (k != 4) begin
        if (!(v > longint'(win[k].m))) gt = 1'b0;
        if (!(v < longint'(win[k].m))) lt = 1'b0;
      end
    end
    mag = (v < 0) ? -v : v;
    res.extremum_kind = EXT_NONE;
    if (mag >= longint'(cfg_thresh_q)) begin
      if (gt) res.extremum_kind = EXT_MAX;
      else if (lt) res.extremum_kind = EXT_MIN;
    end
    if (res.extremum_kind != EXT_NONE) begin
      dxx = 4 * (longint'(win[3].m) + longint'(win[5].m) - 2 * v);
      dyy = 4 * (longint'(win[1].m) + longint'(win[7].m) - 2 * v);
      dxy = longint'(win[0].m) + longint'(win[8].m) - longint'(win[2].m)
            - longint'(win[6].m);
      t   = dxx + dyy;
      det = dxx * dyy - dxy * dxy;
      kk  = (longint'(cfg_ratio_q) + 1) * (longint'(cfg_ratio_q) + 1);
      lhs = t * t * longint'(cfg_ratio_q);
      res.is_keypoint = (det > 0) && (lhs <= det * kk);
    end
    res.center_valid = 1'b1;
    res.center_row   = POS_W'(r - 1);
    res.center_col   = POS_W'(c - 1);
    return res;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch %0s: got %0d, expected %0d (t=%0t)", field, got, want, $time);
    errors++;
  endtask

  // result channel: check and random back-pressure
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report("result count", 1, 0);
      end else begin
        result_t want;
        want = pending_results.pop_front();
        if (out_ch.center_valid !== want.center_valid)
          report("center_valid", out_ch.center_valid, want.center_valid);
        if (out_ch.is_keypoint !== want.is_keypoint)
          report("is_keypoint", out_ch.is_keypoint, want.is_keypoint);
        if (out_ch.extremum_kind !== want.extremum_kind)
          report("extremum_kind", out_ch.extremum_kind, want.extremum_kind);
        if (out_ch.center_row !== want.center_row)
          report("center_row", out_ch.center_row, want.center_row);
        if (out_ch.center_col !== want.center_col)
          report("center_col", out_ch.center_col, want.center_col);
        centre_cnt += want.center_valid;
        key_cnt    += want.is_keypoint;
        max_cnt    += (want.extremum_kind == EXT_MAX);
        min_cnt    += (want.extremum_kind == EXT_MIN);
      end
    end
    if (recv_stall > 0) begin
      recv_stall--;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      recv_stall = $urandom_range(0, 7);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("watchdog: no transaction for %0d cycles", STALL_MAX);
      $display("[dog_extremum_keypoint_detect_unit] ERROR");
      $finish;
    end
  end

  task automatic send_pixel(trip_t px, bit fs, bit has_exp, result_t exp);
    result_t pred;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.dog_below   <= px.b;
    in_ch.dog_mid     <= px.m;
    in_ch.dog_above   <= px.a;
    in_ch.frame_start <= fs;
    do @(posedge clk); while (!in_ch.ready);
    pred = detect_extremum(px, fs);
    pending_results.push_back(has_exp ? exp : pred);
    sent_cnt++;
  endtask

  // hold the sender until every result is back, then let the pipe settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DAT_W'(val);
    @(posedge clk);
  endtask

  task automatic apply_cfg(int unsigned w, int unsigned h, int unsigned thr,
                           int unsigned ratio);
    drain();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_THRESH, thr);
    write_reg(CFG_RATIO, ratio);
    cfg_we <= 1'b0;
    cfg_width_q  = 11'(w);
    cfg_height_q = 11'(h);
    cfg_thresh_q = 15'(thr);
    cfg_ratio_q  = 6'(ratio);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] noise_sample();
    return SAMPLE_W'(int'($urandom_range(0, 400)) - 200);
  endfunction

  function automatic trip_t rand_pixel();
    trip_t px;
    int    mode;
    mode = $urandom_range(0, 19);
    if (mode == 0) begin
      px.b = SAMPLE_W'($urandom);
      px.m = SAMPLE_W'($urandom);
      px.a = SAMPLE_W'($urandom);
    end else if (mode == 1) begin
      px.b = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      px.m = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      px.a = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end else begin
      px.b = noise_sample();
      px.a = noise_sample();
      px.m = noise_sample();
      if ($urandom_range(0, 5) == 0) begin
        px.m = SAMPLE_W'($urandom_range(600, 32767));
        if ($urandom_range(0, 1)) px.m = -px.m;
      end
    end
    return px;
  endfunction

  task automatic run_frames(int n);
    int unsigned w, h, p;
    bit          fs;
    w = (cfg_width_q < 3) ? 3 : (cfg_width_q > MAXW) ? MAXW : cfg_width_q;
    h = (cfg_height_q < 3) ? 3 : (cfg_height_q > MAXH) ? MAXH : cfg_height_q;
    p = 0;
    for (int i = 0; i < n; i++) begin
      fs = (p == 0) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 59) == 0) begin
        fs = 1'b1;
        p  = 0;
      end
      send_pixel(rand_pixel(), fs, 1'b0, '0);
      p = (p + 1 >= w * h) ? 0 : p + 1;
    end
  endtask

  function automatic void build_table();
    int          idx;
    logic signed [SAMPLE_W-1:0] saddle[9];
    saddle = '{16'sd999, 16'sd0, -16'sd3001, 16'sd0, 16'sd1000, 16'sd0,
               -16'sd3001, 16'sd0, 16'sd999};
    for (int f = 0; f < 3; f++) begin
      for (int p = 0; p < 9; p++) begin
        idx = f * 9 + p;
        dir_table[idx].fs      = (p == 0);
        dir_table[idx].has_exp = 1'b1;
        dir_table[idx].exp     = '0;
        case (f)
          0: begin
            dir_table[idx].b = 16'sh8000;
            dir_table[idx].a = 16'sh8000;
            dir_table[idx].m = (p == 4) ? 16'sh7fff : 16'sh8000;
          end
          1: begin
            dir_table[idx].b = 16'sh7fff;
            dir_table[idx].a = 16'sh7fff;
            dir_table[idx].m = (p == 4) ? 16'sh8000 : 16'sh7fff;
          end
          default: begin
            dir_table[idx].b = -16'sd100;
            dir_table[idx].a = -16'sd100;
            dir_table[idx].m = saddle[p];
          end
        endcase
      end
      idx = f * 9 + 8;
      dir_table[idx].exp.center_valid  = 1'b1;
      dir_table[idx].exp.is_keypoint   = (f != 2);
      dir_table[idx].exp.extremum_kind = (f == 1) ? EXT_MIN : EXT_MAX;
      dir_table[idx].exp.center_row    = 10'd1;
      dir_table[idx].exp.center_col    = 10'd1;
    end
  endfunction

  initial begin
    trip_t px;
    build_table();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apply_cfg(3, 3, THRESH_RST, RATIO_RST);
    foreach (dir_table[i]) begin
      px.b = dir_table[i].b;
      px.m = dir_table[i].m;
      px.a = dir_table[i].a;
      send_pixel(px, dir_table[i].fs, dir_table[i].has_exp, dir_table[i].exp);
    end

    apply_cfg(5, 4, 0, 0);
    run_frames(100);
    apply_cfg(0, 0, 16384, 63);
    run_frames(60);
    apply_cfg(7, 5, 300, 1);
    run_frames(120);
    apply_cfg(2047, 2047, 492, 10);
    run_frames(40);
    apply_cfg(6, 6, 200, 10);
    run_frames(100);
    apply_cfg(4, 3, 1, 5);
    idle_on = 1'b0;
    run_frames(100);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("sent %0d pixel triples over 7 size/threshold/ratio settings", sent_cnt);
    $display("evaluated %0d centres: %0d maxima, %0d minima, %0d keypoints",
             centre_cnt, max_cnt, min_cnt, key_cnt);
    if (errors == 0) begin
      $display("[dog_extremum_keypoint_detect_unit] OK");
    end else begin
      $display("[dog_extremum_keypoint_detect_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: dog_extremum_keypoint_detect_unit.f
+incdir+hw/rtl
hw/rtl/dogkp_pkg.sv
hw/rtl/dogkp_if.sv
hw/rtl/dogkp_ctrl.sv
hw/rtl/dogkp_dpath.sv
hw/rtl/dog_extremum_keypoint_detect_unit.sv
verif/tb_dog_extremum_keypoint_detect_unit.sv
